>>> rtl/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants of the PCX run-length palette decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

   // Register and coordinate widths
   localparam int CSR_W          = 16;
   localparam int EXT_W          = CSR_W + 1;
   localparam int COORD_BITS_DEF = 16;
   localparam int RUN_W          = 6;
   localparam int CSR_IDX_W      = 2;

   // Command queue depth between front and back
   localparam int QUEUE_DEPTH = 4;

   // Stream byte codes
   localparam logic [7:0] RUN_MARK    = 8'hC0;
   localparam logic [7:0] RUN_MASK    = 8'h3F;
   localparam logic [7:0] CLEAR_INDEX = 8'hFF;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES   = 2'd2;

   // Item operation
   typedef enum logic {
      OP_PALETTE = 1'b0,
      OP_DATA    = 1'b1
   } op_type;

   // Result kind
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   // Classified command handed from front to back
   typedef struct packed {
      op_type           op;
      logic [RUN_W-1:0] count;
      logic [7:0]       data_byte;
      logic             last_byte;
      logic [7:0]       entry_index;
      logic [7:0]       entry_byte0;
      logic [7:0]       entry_byte1;
      logic [7:0]       entry_byte2;
   } cmd_type;

endpackage

>>> rtl/pcx_rle_palette_decoder_core.sv
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder_core
// Decodes 8-bit PCX run-length data into RGBA pixels through a palette.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: each item is a palette write (operation 0) or one
//    compressed byte (operation 1); req_end_of_data marks the stream's last.
//  - rsp_ channel: one pixel per visible index placed, or a single error
//    result with rsp_last set when the stream ends with the image unfinished.
//  - csr_ port: image width, height and bytes per line, written while idle.
// Timing:
//  - The front takes one item per cycle while the 4-entry command queue has
//    room; the back runs one command at a time.
//  - Palette write: done in the idle state. Data byte: one palette read,
//    then its indices are placed one at a time via the output register.
//  - Final byte of a stream: a further trial pass through the check state
//    that decides between its pixels and the error result.
//  - A byte's first pixel passes the queue, palette read and output register.
// Reset clears the scan position, the queue and the output register; the
//  palette returns to a greyscale ramp and registers to 1.
// A stalled receiver holds the output register; the back waits and the
//  queue then fills before req_ready drops.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder_core
   import pcxrle_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_end_of_data,
   input  logic [7:0]           req_entry_index,
   input  logic [7:0]           req_entry_byte0,
   input  logic [7:0]           req_entry_byte1,
   input  logic [7:0]           req_entry_byte2,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [7:0]           rsp_red,
   output logic [7:0]           rsp_green,
   output logic [7:0]           rsp_blue,
   output logic [7:0]           rsp_alpha,
   output logic                 rsp_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [CSR_W-1:0] width_ff, height_ff, lbytes_ff;
   logic             q_full, q_empty, q_push, q_pop;
   cmd_type          push_cmd, head_cmd;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_W'(1);
         height_ff <= CSR_W'(1);
         lbytes_ff <= CSR_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_LINE_BYTES:   lbytes_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pcxrle_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_data_byte   (req_data_byte),
      .req_end_of_data (req_end_of_data),
      .req_entry_index (req_entry_index),
      .req_entry_byte0 (req_entry_byte0),
      .req_entry_byte1 (req_entry_byte1),
      .req_entry_byte2 (req_entry_byte2),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   pcxrle_cmd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (push_cmd),
      .pop   (q_pop),
      .rdata (head_cmd),
      .full  (q_full),
      .empty (q_empty)
   );

   pcxrle_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_cmd        (head_cmd),
      .q_pop        (q_pop),
      .image_width  (width_ff),
      .image_height (height_ff),
      .line_bytes   (lbytes_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_red      (rsp_red),
      .rsp_green    (rsp_green),
      .rsp_blue     (rsp_blue),
      .rsp_alpha    (rsp_alpha),
      .rsp_last     (rsp_last)
   );

endmodule

>>> rtl/pcxrle_front.sv
// ----------------------------------------------------------------------------
// pcxrle_front
// Accepts input items and turns each into one command: a palette write, or a
// data byte with the number of pixels it places (run headers resolved here).
// ----------------------------------------------------------------------------
module pcxrle_front
   import pcxrle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_data,
   input  logic [7:0] req_entry_index,
   input  logic [7:0] req_entry_byte0,
   input  logic [7:0] req_entry_byte1,
   input  logic [7:0] req_entry_byte2,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   logic             pend_ff, pend_in;
   logic [RUN_W-1:0] plen_ff, plen_in;
   logic             is_data;
   logic             is_header;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign is_data   = (req_operation == OP_DATA);
   assign is_header = ((req_data_byte & RUN_MARK) == RUN_MARK);

   // Classify the item and track a pending run header
   always_comb begin
      pend_in           = pend_ff;
      plen_in           = plen_ff;
      q_cmd.op          = is_data ? OP_DATA : OP_PALETTE;
      q_cmd.count       = '0;
      q_cmd.data_byte   = req_data_byte;
      q_cmd.last_byte   = req_end_of_data;
      q_cmd.entry_index = req_entry_index;
      q_cmd.entry_byte0 = req_entry_byte0;
      q_cmd.entry_byte1 = req_entry_byte1;
      q_cmd.entry_byte2 = req_entry_byte2;
      if (is_data) begin
         if (pend_ff) begin
            q_cmd.count = plen_ff;
            pend_in     = 1'b0;
         end else if (is_header) begin
            pend_in = 1'b1;
            plen_in = req_data_byte[RUN_W-1:0] & RUN_MASK[RUN_W-1:0];
         end else begin
            q_cmd.count = {{(RUN_W-1){1'b0}}, 1'b1};
         end
         if (req_end_of_data) begin
            pend_in = 1'b0;
         end
      end
   end

   // Advance pending run state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         plen_ff <= '0;
      end else if (q_push) begin
         pend_ff <= pend_in;
         plen_ff <= plen_in;
      end
   end

endmodule

>>> rtl/pcxrle_cmd_queue.sv
// ----------------------------------------------------------------------------
// pcxrle_cmd_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module pcxrle_cmd_queue
   import pcxrle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wdata,
   input  logic    pop,
   output cmd_type rdata,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   assign full  = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign rdata = slot_ff[rd_ptr_ff];

   // Move pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/pcxrle_place.sv
// ----------------------------------------------------------------------------
// pcxrle_place
// Places one decoded index at the current column and row: visibility, last
// flag and the next position of the scan.
// ----------------------------------------------------------------------------
module pcxrle_place
   import pcxrle_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic [COORD_BITS-1:0] col,
   input  logic [COORD_BITS-1:0] row,
   input  logic [CSR_W-1:0]      image_width,
   input  logic [CSR_W-1:0]      image_height,
   input  logic [CSR_W-1:0]      line_bytes,
   output logic                  visible,
   output logic                  last,
   output logic [COORD_BITS-1:0] col_next,
   output logic [COORD_BITS-1:0] row_next,
   output logic                  done
);

   logic [COORD_BITS-1:0] nc, nr;
   logic [EXT_W-1:0]      col_x, col_p1_x, nc_x, nr_x;
   logic [EXT_W-1:0]      wid_x, hgt_x, lb_x;
   logic                  row_end, img_end;

   always_comb begin
      nc       = col + COORD_BITS'(1);
      nr       = row + COORD_BITS'(1);
      col_x    = {{(EXT_W-COORD_BITS){1'b0}}, col};
      col_p1_x = col_x + EXT_W'(1);
      nc_x     = {{(EXT_W-COORD_BITS){1'b0}}, nc};
      nr_x     = {{(EXT_W-COORD_BITS){1'b0}}, nr};
      wid_x    = {1'b0, image_width};
      hgt_x    = {1'b0, image_height};
      lb_x     = {1'b0, line_bytes};

      // Row closes on wrap or at line length; image closes likewise on rows
      row_end = (nc == '0) || (nc_x >= lb_x);
      img_end = (nr == '0) || (nr_x >= hgt_x);

      visible = (col_x < wid_x) && (col_x < lb_x);
      last    = ((col_p1_x >= wid_x) || (col_p1_x >= lb_x)) && img_end;

      col_next = row_end ? '0 : nc;
      row_next = row_end ? (img_end ? '0 : nr) : row;
      done     = row_end && img_end;
   end

endmodule

>>> rtl/pcxrle_back.sv
// ----------------------------------------------------------------------------
// pcxrle_back
// Carries out commands: palette writes, pixel runs through the palette
// memory, the completion check on the final byte and the error result.
// ----------------------------------------------------------------------------
module pcxrle_back
   import pcxrle_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  cmd_type          q_cmd,
   output logic             q_pop,
   input  logic [CSR_W-1:0] image_width,
   input  logic [CSR_W-1:0] image_height,
   input  logic [CSR_W-1:0] line_bytes,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_kind,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic             rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_ERROR = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic                  done_ff, done_in;
   logic [COORD_BITS-1:0] chk_col_ff, chk_col_in, chk_row_ff, chk_row_in;
   logic                  chk_done_ff, chk_done_in;
   logic [RUN_W-1:0]      chk_cnt_ff, chk_cnt_in;
   logic [RUN_W-1:0]      cnt_ff, cnt_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  end_ff, end_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [7:0]            rsp_red_ff, rsp_red_in;
   logic [7:0]            rsp_green_ff, rsp_green_in;
   logic [7:0]            rsp_blue_ff, rsp_blue_in;
   logic [7:0]            rsp_alpha_ff, rsp_alpha_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [23:0]           pal_mem [256];
   logic [255:0]          pal_valid_ff;
   logic [23:0]           pal_rd_ff;
   logic                  pal_ok_ff;
   logic                  pal_we, pal_re;
   logic [23:0]           color;

   logic                  emit_ok;
   logic                  p_vis, p_last, p_done;
   logic [COORD_BITS-1:0] p_col, p_row;
   logic                  c_vis, c_last, c_done;
   logic [COORD_BITS-1:0] c_col, c_row;

   // Real scan position
   pcxrle_place #(.COORD_BITS(COORD_BITS)) u_place (
      .col          (col_ff),
      .row          (row_ff),
      .image_width  (image_width),
      .image_height (image_height),
      .line_bytes   (line_bytes),
      .visible      (p_vis),
      .last         (p_last),
      .col_next     (p_col),
      .row_next     (p_row),
      .done         (p_done)
   );

   // Trial scan position for the completion check
   pcxrle_place #(.COORD_BITS(COORD_BITS)) u_check (
      .col          (chk_col_ff),
      .row          (chk_row_ff),
      .image_width  (image_width),
      .image_height (image_height),
      .line_bytes   (line_bytes),
      .visible      (c_vis),
      .last         (c_last),
      .col_next     (c_col),
      .row_next     (c_row),
      .done         (c_done)
   );

   assign emit_ok = !rsp_valid_ff || rsp_ready;
   assign color   = pal_ok_ff ? pal_rd_ff : {byte_ff, byte_ff, byte_ff};

   // Sequence the commands
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      done_in      = done_ff;
      chk_col_in   = chk_col_ff;
      chk_row_in   = chk_row_ff;
      chk_done_in  = chk_done_ff;
      chk_cnt_in   = chk_cnt_ff;
      cnt_in       = cnt_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      q_pop        = 1'b0;
      pal_we       = 1'b0;
      pal_re       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_cmd.op == OP_PALETTE) begin
                  pal_we = 1'b1;
               end else begin
                  pal_re  = 1'b1;
                  byte_in = q_cmd.data_byte;
                  cnt_in  = q_cmd.count;
                  end_in  = q_cmd.last_byte;
                  if (done_ff) begin
                     // Image already complete: drop the byte, restart at stream end
                     if (q_cmd.last_byte) begin
                        col_in  = '0;
                        row_in  = '0;
                        done_in = 1'b0;
                     end
                  end else if (q_cmd.last_byte) begin
                     chk_col_in  = col_ff;
                     chk_row_in  = row_ff;
                     chk_done_in = 1'b0;
                     chk_cnt_in  = q_cmd.count;
                     state_in    = ST_CHECK;
                  end else if (q_cmd.count != '0) begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_CHECK: begin
            // Dry run of the final byte: emit only if it completes the image
            if (chk_done_ff) begin
               state_in = ST_EMIT;
            end else if (chk_cnt_ff == '0) begin
               state_in = ST_ERROR;
            end else begin
               chk_col_in  = c_col;
               chk_row_in  = c_row;
               chk_done_in = c_done;
               chk_cnt_in  = chk_cnt_ff - RUN_W'(1);
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               if (p_vis) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_PIXEL;
                  rsp_red_in   = color[23:16];
                  rsp_green_in = color[15:8];
                  rsp_blue_in  = color[7:0];
                  rsp_alpha_in = (byte_ff == CLEAR_INDEX) ? ALPHA_CLEAR : ALPHA_OPAQUE;
                  rsp_last_in  = p_last;
               end
               cnt_in  = cnt_ff - RUN_W'(1);
               col_in  = p_col;
               row_in  = p_row;
               done_in = p_done;
               if ((cnt_ff == RUN_W'(1)) || p_done) begin
                  state_in = ST_IDLE;
                  if (end_ff) begin
                     col_in  = '0;
                     row_in  = '0;
                     done_in = 1'b0;
                  end
               end
            end
         end
         ST_ERROR: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ERROR;
               rsp_red_in   = '0;
               rsp_green_in = '0;
               rsp_blue_in  = '0;
               rsp_alpha_in = '0;
               rsp_last_in  = 1'b1;
               col_in       = '0;
               row_in       = '0;
               done_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pal_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pal_we) begin
            pal_valid_ff[q_cmd.entry_index] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_col_ff   <= chk_col_in;
      chk_row_ff   <= chk_row_in;
      chk_done_ff  <= chk_done_in;
      chk_cnt_ff   <= chk_cnt_in;
      cnt_ff       <= cnt_in;
      byte_ff      <= byte_in;
      end_ff       <= end_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Palette memory; unwritten entries read as the greyscale ramp
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[q_cmd.entry_index] <= {q_cmd.entry_byte2, q_cmd.entry_byte1,
                                        q_cmd.entry_byte0};
      end
      if (pal_re) begin
         pal_rd_ff <= pal_mem[q_cmd.data_byte];
         pal_ok_ff <= pal_valid_ff[q_cmd.data_byte];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;
   assign rsp_alpha = rsp_alpha_ff;
   assign rsp_last  = rsp_last_ff;

   // A run in progress has pixels left and an open image
   a_emit_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff != '0) && !done_ff)
      else $error("emit state with empty run or finished image");

   // The completion check only runs for the final byte of a stream
   a_check_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> end_ff)
      else $error("completion check on a byte that does not end the stream");

   // The error state is reached only through a failed completion check
   a_error_entry: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ERROR) && ($past(state_ff) != ST_ERROR))
         |-> ($past(state_ff) == ST_CHECK))
      else $error("error state entered without a completion check");

   // Delivering the error restarts the scan
   a_error_clear: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ERROR) && emit_ok)
         |=> (col_ff == '0) && (row_ff == '0) && !done_ff && rsp_valid_ff)
      else $error("scan not restarted after error result");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCX run-length palette decoder core.
// Items are driven on the req_ channel with random gaps. A scoreboard decodes
// each accepted item into the RGBA pixels or short-data error it should give,
// and every rsp_ item is checked against the oldest pending pixel. The run
// walks through several image geometries and includes one long receiver
// stall that backs the core up into its input.
// ----------------------------------------------------------------------------
module tb
   import pcxrle_pkg::*;
();

   localparam int          RANDOM_ITEMS = 500;
   localparam int          QUIET_TAIL   = 100;
   localparam int          DRAIN_PAD    = 600;
   localparam int          STALL_LIMIT  = 5000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int unsigned COORD_MASK   = (1 << COORD_BITS_DEF) - 1;

   typedef struct packed {
      logic       kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } pixel_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       end_of_data;
      logic [7:0] entry_index;
      logic [7:0] entry_byte0;
      logic [7:0] entry_byte1;
      logic [7:0] entry_byte2;
   } req_item_type;

   // -------------------------------------------------------------------------
   // Scoreboard: decodes accepted items into expected pixels and checks them
   // -------------------------------------------------------------------------
   class pixel_scoreboard_type;
      pixel_type   expected_q[$];
      pixel_type   step_q[$];
      logic [23:0] palette[256];
      bit          run_pending;
      int unsigned run_len;
      int unsigned col;
      int unsigned row;
      bit          img_done;
      int unsigned width;
      int unsigned height;
      int unsigned line_bytes;
      int unsigned mismatches;
      int unsigned pixels_checked;
      int unsigned errors_checked;

      function new();
         width      = 1;
         height     = 1;
         line_bytes = 1;
         for (int i = 0; i < 256; i++) begin
            palette[i] = {3{8'(i)}};
         end
         clear_scan();
         mismatches     = 0;
         pixels_checked = 0;
         errors_checked = 0;
      endfunction

      function void clear_scan();
         run_pending = 0;
         run_len     = 0;
         col         = 0;
         row         = 0;
         img_done    = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_IMAGE_WIDTH:  width      = 32'(value);
            CSR_IMAGE_HEIGHT: height     = 32'(value);
            CSR_LINE_BYTES:   line_bytes = 32'(value);
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Place one index on the scan line; emit a pixel if the column is visible
      function void decode_index(logic [7:0] idx);
         int unsigned next_col;
         int unsigned next_row;
         bit          row_end;
         bit          img_end;
         bit          last_col;
         pixel_type   px;
         next_col = (col + 1) & COORD_MASK;
         next_row = (row + 1) & COORD_MASK;
         row_end  = (next_col == 0) || (next_col >= line_bytes);
         img_end  = (next_row == 0) || (next_row >= height);
         if (col < width && col < line_bytes) begin
            last_col = (col + 1 >= width) || (col + 1 >= line_bytes);
            px.kind  = KIND_PIXEL;
            px.red   = palette[idx][23:16];
            px.green = palette[idx][15:8];
            px.blue  = palette[idx][7:0];
            px.alpha = (idx == CLEAR_INDEX) ? ALPHA_CLEAR : ALPHA_OPAQUE;
            px.last  = last_col && img_end;
            step_q.push_back(px);
         end
         if (row_end) begin
            col = 0;
            if (img_end) begin
               row      = 0;
               img_done = 1;
            end else begin
               row = next_row;
            end
         end else begin
            col = next_col;
         end
      endfunction

      function void note_item(req_item_type it);
         int unsigned n;
         pixel_type   err;
         if (it.op == OP_PALETTE) begin
            palette[it.entry_index] = {it.entry_byte2, it.entry_byte1, it.entry_byte0};
            return;
         end
         step_q.delete();
         if (!img_done) begin
            if (run_pending) begin
               n           = run_len;
               run_pending = 0;
               run_len     = 0;
               while (n > 0 && !img_done) begin
                  decode_index(it.data_byte);
                  n--;
               end
            end else if ((it.data_byte & RUN_MARK) == RUN_MARK) begin
               run_pending = 1;
               run_len     = 32'(it.data_byte & RUN_MASK);
            end else begin
               decode_index(it.data_byte);
            end
         end
         // Stream end: an unfinished image replaces its pixels by one error
         if (it.end_of_data) begin
            if (!img_done) begin
               step_q.delete();
               err      = '0;
               err.kind = KIND_ERROR;
               err.last = 1'b1;
               step_q.push_back(err);
            end
            clear_scan();
         end
         foreach (step_q[i]) expected_q.push_back(step_q[i]);
      endfunction

      function void check_result(pixel_type got);
         pixel_type exp_px;
         bit        bad;
         if (expected_q.size() == 0) begin
            if (mismatches < 10) begin
               $display("[%0t] unexpected result: kind=%0d rgba=%02x%02x%02x%02x last=%0d",
                        $realtime, got.kind, got.red, got.green, got.blue, got.alpha,
                        got.last);
            end
            mismatches++;
            return;
         end
         exp_px = expected_q.pop_front();
         bad = (got.kind !== exp_px.kind) || (got.red !== exp_px.red) ||
               (got.green !== exp_px.green) || (got.blue !== exp_px.blue) ||
               (got.alpha !== exp_px.alpha) || (got.last !== exp_px.last);
         if (bad) begin
            if (mismatches < 10) begin
               $display("[%0t] mismatch: expected kind=%0d rgba=%02x%02x%02x%02x last=%0d",
                        $realtime, exp_px.kind, exp_px.red, exp_px.green, exp_px.blue,
                        exp_px.alpha, exp_px.last);
               $display("[%0t]           got      kind=%0d rgba=%02x%02x%02x%02x last=%0d",
                        $realtime, got.kind, got.red, got.green, got.blue, got.alpha,
                        got.last);
            end
            mismatches++;
         end
         if (exp_px.kind == KIND_ERROR) errors_checked++;
         else pixels_checked++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and instance
   // -------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_operation;
   logic [7:0]           req_data_byte;
   logic                 req_end_of_data;
   logic [7:0]           req_entry_index;
   logic [7:0]           req_entry_byte0;
   logic [7:0]           req_entry_byte1;
   logic [7:0]           req_entry_byte2;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_kind;
   logic [7:0]           rsp_red;
   logic [7:0]           rsp_green;
   logic [7:0]           rsp_blue;
   logic [7:0]           rsp_alpha;
   logic                 rsp_last;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   pixel_scoreboard_type sb;
   bit                   idle_on;
   int unsigned          hold_left;
   int unsigned          items_sent;
   int unsigned          palette_writes;
   int unsigned          streams_sent;
   int unsigned          idle_cycles;
   int unsigned          cur_w;
   int unsigned          cur_h;
   int unsigned          cur_lb;

   pcx_rle_palette_decoder_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_data_byte   (req_data_byte),
      .req_end_of_data (req_end_of_data),
      .req_entry_index (req_entry_index),
      .req_entry_byte0 (req_entry_byte0),
      .req_entry_byte1 (req_entry_byte1),
      .req_entry_byte2 (req_entry_byte2),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run if neither channel moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: check each accepted result, stall in bursts or on request
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned stall;
      pixel_type   got;
      stall = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_last};
            sb.check_result(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 6) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------
   // Offer one item, optionally after a gap; hold it until accepted
   task automatic send_item(input req_item_type it);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= it.op;
      req_data_byte   <= it.data_byte;
      req_end_of_data <= it.end_of_data;
      req_entry_index <= it.entry_index;
      req_entry_byte0 <= it.entry_byte0;
      req_entry_byte1 <= it.entry_byte1;
      req_entry_byte2 <= it.entry_byte2;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_item(it);
      items_sent++;
   endtask

   // Data byte with junk in the palette fields
   task automatic send_data(input logic [7:0] b, input logic eod);
      req_item_type it;
      it.op          = OP_DATA;
      it.data_byte   = b;
      it.end_of_data = eod;
      it.entry_index = 8'($urandom_range(0, 255));
      it.entry_byte0 = 8'($urandom_range(0, 255));
      it.entry_byte1 = 8'($urandom_range(0, 255));
      it.entry_byte2 = 8'($urandom_range(0, 255));
      send_item(it);
   endtask

   // Palette write with junk in the data fields
   task automatic send_palette(input logic [7:0] idx, input logic [7:0] b0,
                               input logic [7:0] b1, input logic [7:0] b2);
      req_item_type it;
      it.op          = OP_PALETTE;
      it.data_byte   = 8'($urandom_range(0, 255));
      it.end_of_data = 1'($urandom_range(0, 1));
      it.entry_index = idx;
      it.entry_byte0 = b0;
      it.entry_byte1 = b1;
      it.entry_byte2 = b2;
      send_item(it);
      palette_writes++;
   endtask

   task automatic send_random_palette();
      send_palette(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   // Drop valid, wait for every pending pixel, then let the back end settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // Write all three geometry registers; call only while idle
   task automatic configure(input logic [CSR_W-1:0] w, input logic [CSR_W-1:0] h,
                            input logic [CSR_W-1:0] lb);
      cur_w  = 32'(w);
      cur_h  = 32'(h);
      cur_lb = 32'(lb);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      sb.set_reg(CSR_IMAGE_WIDTH, w);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      sb.set_reg(CSR_IMAGE_HEIGHT, h);
      csr_index <= CSR_LINE_BYTES;
      csr_wdata <= lb;
      @(posedge clock);
      sb.set_reg(CSR_LINE_BYTES, lb);
      csr_we <= 1'b0;
   endtask

   // One image worth of runs and literals, mostly complete, sometimes cut short
   task automatic send_stream();
      int unsigned total;
      int unsigned target;
      int unsigned filled;
      int unsigned n;
      int unsigned ending;
      total  = cur_lb * cur_h;
      target = ($urandom_range(0, 5) == 0) ? $urandom_range(0, total - 1) : total;
      filled = 0;
      while (filled < target) begin
         if ($urandom_range(0, 7) == 0) send_random_palette();
         if ($urandom_range(0, 2) == 0) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
            send_data(RUN_MARK | 8'(n), 1'b0);
            send_data(8'($urandom_range(0, 255)), 1'b0);
            filled += n;
         end else begin
            send_data(8'($urandom_range(0, 191)), 1'b0);
            filled++;
         end
      end
      ending = $urandom_range(0, 5);
      case (ending)
         0: send_data(RUN_MARK | 8'($urandom_range(0, 63)), 1'b1);
         1, 2: begin
            repeat ($urandom_range(1, 3)) send_data(8'($urandom_range(0, 255)), 1'b0);
            send_data(8'($urandom_range(0, 191)), 1'b1);
         end
         3: begin
            // broken tail: random byte with random end flag
            send_data(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_data(8'($urandom_range(0, 191)), 1'b1);
         end
         default: send_data(8'($urandom_range(0, 191)), 1'b1);
      endcase
      streams_sent++;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main_seq
      int unsigned random_start;
      int unsigned phase;
      int unsigned w;
      bit          failed;
      sb              = new();
      idle_on         = 1;
      hold_left       = 0;
      items_sent      = 0;
      palette_writes  = 0;
      streams_sent    = 0;
      idle_cycles     = 0;
      cur_w           = 1;
      cur_h           = 1;
      cur_lb          = 1;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_DATA;
      req_data_byte   = '0;
      req_end_of_data = 1'b0;
      req_entry_index = '0;
      req_entry_byte0 = '0;
      req_entry_byte1 = '0;
      req_entry_byte2 = '0;
      rsp_ready       = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_IMAGE_WIDTH;
      csr_wdata       = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset geometry 1x1: single pixel image, ignored tail, run header at end
      send_data(8'h00, 1'b0);
      send_data(8'h05, 1'b1);
      send_data(8'hC1, 1'b1);
      wait_idle();

      // 3 visible of 5 per line, 2 lines
      configure(16'd3, 16'd2, 16'd5);
      send_palette(CLEAR_INDEX, 8'h10, 8'h20, 8'h30);
      send_palette(8'h00, 8'hFF, 8'hFF, 8'hFF);
      send_palette(8'h80, 8'h00, 8'h00, 8'h00);
      send_data(8'hC3, 1'b0);           // run of three transparent pixels
      send_data(8'hFF, 1'b0);
      send_data(8'hC0, 1'b0);           // zero-length run swallows next byte
      send_data(8'h44, 1'b0);
      send_data(8'h3F, 1'b0);           // padding
      send_data(8'h01, 1'b0);           // padding, closes the line
      send_data(8'hC1, 1'b0);           // run byte that looks like a header
      send_data(8'hC1, 1'b0);
      send_data(8'h80, 1'b0);
      send_palette(8'h80, 8'h55, 8'h66, 8'h77);  // mid-image palette change
      send_data(8'hC2, 1'b0);
      send_data(8'h80, 1'b0);
      send_data(8'h12, 1'b0);           // completes the image
      send_data(8'h34, 1'b1);           // ignored, ends stream cleanly
      // Data ends inside the padding of the last line
      send_data(8'hC8, 1'b0);
      send_data(8'h09, 1'b0);
      send_data(8'h09, 1'b1);
      wait_idle();

      // Largest geometry: a long run, then the stream ends short of the image
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_data(8'hFF, 1'b0);
      send_data(8'h20, 1'b0);
      send_data(8'h7F, 1'b1);
      wait_idle();

      // Random geometries and streams
      random_start = items_sent;
      phase        = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (items_sent - random_start > RANDOM_ITEMS - QUIET_TAIL) idle_on = 0;
         w = $urandom_range(1, 8);
         if ($urandom_range(0, 4) == 0) begin
            configure(16'(w), 16'($urandom_range(1, 4)), 16'($urandom_range(1, w)));
         end else begin
            configure(16'(w), 16'($urandom_range(1, 4)), 16'(w + $urandom_range(0, 3)));
         end
         // Hold off the receiver once so the core backs up into req_ready
         if (phase == 2) hold_left = HOLD_CYCLES;
         repeat ($urandom_range(2, 5)) send_stream();
         wait_idle();
         phase++;
      end

      // Back to the smallest geometry for a final pair of streams
      configure(16'd1, 16'd1, 16'd1);
      send_stream();
      send_stream();
      wait_idle();

      failed = (sb.mismatches != 0) || (sb.pending() != 0);
      if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
      $display("Covered %0d items (%0d palette writes, %0d random streams).",
               items_sent, palette_writes, streams_sent);
      $display("Checked %0d pixels and %0d short-data errors; %0d mismatches.",
               sb.pixels_checked, sb.errors_checked, sb.mismatches);
      if (!failed) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/pcxrle_pkg.sv
rtl/pcxrle_front.sv
rtl/pcxrle_cmd_queue.sv
rtl/pcxrle_place.sv
rtl/pcxrle_back.sv
rtl/pcx_rle_palette_decoder_core.sv
tb/tb.sv
